// ===== rtl/xtd_pkg.sv =====
// Shared types, character constants and entity tables of the XML text entity decoder.
// No dependencies; every other file of the block imports this package.
package xtd_pkg;

	// Status codes of a result beat.
	localparam logic [2:0] ST_BYTE      = 3'd0;
	localparam logic [2:0] ST_TEXT_END  = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_EARLY_END = 3'd4;

	// Kind of numeric reference being collected.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DEC  = 2'd1;
	localparam logic [1:0] KIND_HEX  = 2'd2;

	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_1B_MAX = 21'h00007F;
	localparam logic [CP_W-1:0] CP_2B_MAX = 21'h0007FF;
	localparam logic [CP_W-1:0] CP_3B_MAX = 21'h00FFFF;

	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [5:0] UTF8_MASK  = 6'h3F;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_XL   = 8'h78;
	localparam logic [7:0] CH_XU   = 8'h58;

	localparam int DEF_MAX_SCAN = 64;
	localparam int QUEUE_DEPTH  = 4;
	localparam int NUM_ENT      = 5;

	// One queued action for the output side.
	typedef struct packed {
		logic [2:0]      status;
		logic            raw;
		logic [CP_W-1:0] cp;
	} cmd_t;

	// Length of the named entities amp, lt, gt, quot, apos.
	function automatic logic [2:0] ent_len(input logic [2:0] k);
		case (k)
			3'd0: ent_len = 3'd3;
			3'd1: ent_len = 3'd2;
			3'd2: ent_len = 3'd2;
			3'd3: ent_len = 3'd4;
			3'd4: ent_len = 3'd4;
			default: ent_len = 3'd0;
		endcase
	endfunction

	// Character that a named entity stands for.
	function automatic logic [7:0] ent_char(input logic [2:0] k);
		case (k)
			3'd0: ent_char = 8'h26;
			3'd1: ent_char = 8'h3C;
			3'd2: ent_char = 8'h3E;
			3'd3: ent_char = 8'h22;
			3'd4: ent_char = 8'h27;
			default: ent_char = 8'h00;
		endcase
	endfunction

	// Byte of an entity name at a given position.
	function automatic logic [7:0] ent_byte(input logic [2:0] k, input logic [1:0] p);
		case ({k, p})
			{3'd0, 2'd0}: ent_byte = 8'h61;
			{3'd0, 2'd1}: ent_byte = 8'h6D;
			{3'd0, 2'd2}: ent_byte = 8'h70;
			{3'd1, 2'd0}: ent_byte = 8'h6C;
			{3'd1, 2'd1}: ent_byte = 8'h74;
			{3'd2, 2'd0}: ent_byte = 8'h67;
			{3'd2, 2'd1}: ent_byte = 8'h74;
			{3'd3, 2'd0}: ent_byte = 8'h71;
			{3'd3, 2'd1}: ent_byte = 8'h75;
			{3'd3, 2'd2}: ent_byte = 8'h6F;
			{3'd3, 2'd3}: ent_byte = 8'h74;
			{3'd4, 2'd0}: ent_byte = 8'h61;
			{3'd4, 2'd1}: ent_byte = 8'h70;
			{3'd4, 2'd2}: ent_byte = 8'h6F;
			{3'd4, 2'd3}: ent_byte = 8'h73;
			default: ent_byte = 8'h00;
		endcase
	endfunction

endpackage

// ===== rtl/xml_text_entity_decoder_top.sv =====
// XML text entity decoder: takes element text one byte a beat and returns the
// text with character and entity references replaced by UTF-8. Every input byte
// is accepted while the queue has room; a beat that ends an item places one
// action in a four-entry queue. The output register then sends one beat per
// cycle while the receiver is ready: one for a plain byte, a named entity or a
// status, and 1 to 4 for a numeric reference, and the input stalls only once
// the queue has filled. There is no clearing pass after reset. Depends on
// xtd_pkg, xtd_front, xtd_queue and xtd_back.
module xml_text_entity_decoder_top #(
	parameter int MAX_REFERENCE_SCAN = xtd_pkg::DEF_MAX_SCAN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic [0:0] s_tuser,   // [0] input_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [2:0] status
	output logic       m_tlast    // last
);
	import xtd_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	xtd_front #(
		.MAX_REFERENCE_SCAN(MAX_REFERENCE_SCAN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	xtd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	xtd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== rtl/xtd_front.sv =====
// Input side of the decoder: takes text beats, tracks reference bodies and
// emits one action per finished item into the queue. Depends on xtd_pkg.
module xtd_front #(
	parameter int MAX_REFERENCE_SCAN = xtd_pkg::DEF_MAX_SCAN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [0:0]        s_tuser,
	input  logic              q_full,
	output logic              push,
	output xtd_pkg::cmd_t     push_cmd
);
	import xtd_pkg::*;

	localparam int CW = $clog2(MAX_REFERENCE_SCAN + 1);
	localparam logic [CW-1:0] SCAN_LIMIT = CW'(MAX_REFERENCE_SCAN);

	logic              in_ref_q;
	logic [CW-1:0]     body_cnt_q;
	logic [NUM_ENT-1:0] cand_q;
	logic [1:0]        kind_q;
	logic [CP_W-1:0]   val_q;
	logic [3:0]        dig_q;
	logic              bad_q;

	logic              in_ref_d;
	logic [CW-1:0]     body_cnt_d;
	logic [NUM_ENT-1:0] cand_d;
	logic [1:0]        kind_d;
	logic [CP_W-1:0]   val_d;
	logic [3:0]        dig_d;
	logic              bad_d;

	logic              accept;
	logic [7:0]        c;
	logic              is_end;
	logic              is_dec, is_lo, is_up;
	logic [3:0]        hd;
	logic [23:0]       dec_prod;
	logic [CP_W-1:0]   hex_new;
	logic              hex_big;
	logic [NUM_ENT-1:0] cand_keep;
	logic [NUM_ENT-1:0] len_hit;
	logic              named_hit;
	logic [7:0]        named_ch;
	logic              num_bad;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata;
	assign is_end   = s_tuser[0];

	assign is_dec = (c >= 8'h30) && (c <= 8'h39);
	assign is_lo  = (c >= 8'h61) && (c <= 8'h66);
	assign is_up  = (c >= 8'h41) && (c <= 8'h46);
	// Letters a-f and A-F carry 1..6 in the low nibble.
	assign hd       = is_dec ? c[3:0] : c[3:0] + 4'd9;
	assign dec_prod = ({3'b0, val_q} << 3) + ({3'b0, val_q} << 1) + {20'b0, c[3:0]};
	assign hex_new  = {val_q[CP_W-5:0], hd};
	assign hex_big  = (val_q[CP_W-1:CP_W-4] != 4'd0) || (hex_new > CP_MAX);

	always_comb begin
		cand_keep = '0;
		len_hit   = '0;
		named_ch  = 8'h00;
		for (int k = 0; k < NUM_ENT; k++) begin
			cand_keep[k] = (body_cnt_q < CW'(ent_len(3'(k)))) &&
				(ent_byte(3'(k), body_cnt_q[1:0]) == c);
			len_hit[k] = cand_q[k] && (body_cnt_q == CW'(ent_len(3'(k))));
			if (len_hit[k])
				named_ch = ent_char(3'(k));
		end
	end

	assign named_hit = |len_hit;
	assign num_bad = bad_q || (dig_q == 4'd0) || (val_q == '0) ||
		((val_q >= SURR_LO) && (val_q <= SURR_HI));

	always_comb begin
		push       = 1'b0;
		push_cmd   = '0;
		in_ref_d   = in_ref_q;
		body_cnt_d = body_cnt_q;
		cand_d     = cand_q;
		kind_d     = kind_q;
		val_d      = val_q;
		dig_d      = dig_q;
		bad_d      = bad_q;
		if (accept) begin
			if (!in_ref_q) begin
				if (is_end) begin
					push = 1'b1;
					push_cmd.status = ST_EARLY_END;
				end else if (c == CH_LT) begin
					push = 1'b1;
					push_cmd.status = ST_TEXT_END;
				end else if (c == CH_AMP) begin
					in_ref_d = 1'b1;
				end else begin
					push = 1'b1;
					push_cmd.status = ST_BYTE;
					push_cmd.raw    = 1'b1;
					push_cmd.cp     = {13'b0, c};
				end
			end else if (is_end || (c != CH_SEMI && body_cnt_q >= SCAN_LIMIT)) begin
				push = 1'b1;
				push_cmd.status = ST_MALFORMED;
				in_ref_d = 1'b0;
			end else if (c == CH_SEMI) begin
				push = 1'b1;
				in_ref_d = 1'b0;
				if (named_hit) begin
					push_cmd.status = ST_BYTE;
					push_cmd.raw    = 1'b1;
					push_cmd.cp     = {13'b0, named_ch};
				end else if (kind_q == KIND_NONE) begin
					push_cmd.status = ST_UNKNOWN;
				end else if (num_bad) begin
					push_cmd.status = ST_MALFORMED;
				end else begin
					push_cmd.status = ST_BYTE;
					push_cmd.cp     = val_q;
				end
			end else begin
				cand_d     = cand_q & cand_keep;
				body_cnt_d = body_cnt_q + 1'b1;
				if (body_cnt_q == '0) begin
					if (c == CH_HASH)
						kind_d = KIND_DEC;
				end else if (kind_q != KIND_NONE) begin
					if (body_cnt_q == CW'(1) && (c == CH_XL || c == CH_XU)) begin
						kind_d = KIND_HEX;
					end else if (!bad_q) begin
						if (kind_q == KIND_HEX) begin
							if (!(is_dec || is_lo || is_up) || dig_q >= 4'd8) begin
								bad_d = 1'b1;
							end else begin
								val_d = hex_new;
								dig_d = dig_q + 4'd1;
								bad_d = hex_big;
							end
						end else begin
							if (!is_dec || dig_q >= 4'd10 || dec_prod > {3'b0, CP_MAX}) begin
								bad_d = 1'b1;
							end else begin
								val_d = dec_prod[CP_W-1:0];
								dig_d = dig_q + 4'd1;
							end
						end
					end
				end
			end
			// Leaving a reference, or opening one, starts from a clean body.
			if (!in_ref_d || !in_ref_q) begin
				body_cnt_d = '0;
				cand_d     = '1;
				kind_d     = KIND_NONE;
				val_d      = '0;
				dig_d      = 4'd0;
				bad_d      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ref_q   <= 1'b0;
			body_cnt_q <= '0;
			cand_q     <= '1;
			kind_q     <= KIND_NONE;
			val_q      <= '0;
			dig_q      <= 4'd0;
			bad_q      <= 1'b0;
		end else begin
			in_ref_q   <= in_ref_d;
			body_cnt_q <= body_cnt_d;
			cand_q     <= cand_d;
			kind_q     <= kind_d;
			val_q      <= val_d;
			dig_q      <= dig_d;
			bad_q      <= bad_d;
		end
	end

endmodule

// ===== rtl/xtd_queue.sv =====
// Short action queue between the input and output sides of the decoder.
// Depends on xtd_pkg for the action type and the queue depth.
module xtd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xtd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output xtd_pkg::cmd_t head
);
	import xtd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [NW-1:0] FULL_CNT = NW'(QUEUE_DEPTH);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/xtd_back.sv =====
// Output side of the decoder: expands queued actions into UTF-8 or status beats
// through a registered master port. Depends on xtd_pkg.
module xtd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  xtd_pkg::cmd_t head,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic [2:0]    m_tuser,
	output logic          m_tlast
);
	import xtd_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] n_m1;
	logic [7:0] byte_val;
	logic       load;
	logic       is_last;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic [2:0] m_tuser_q;
	logic       m_tlast_q;

	always_comb begin
		if (head.status != ST_BYTE || head.raw || head.cp <= CP_1B_MAX)
			n_m1 = 2'd0;
		else if (head.cp <= CP_2B_MAX)
			n_m1 = 2'd1;
		else if (head.cp <= CP_3B_MAX)
			n_m1 = 2'd2;
		else
			n_m1 = 2'd3;
	end

	always_comb begin
		case ({n_m1, idx_q})
			{2'd0, 2'd0}: byte_val = (head.status == ST_BYTE) ? head.cp[7:0] : 8'h00;
			{2'd1, 2'd0}: byte_val = UTF8_LEAD2 | {3'b0, head.cp[10:6]};
			{2'd1, 2'd1}: byte_val = UTF8_CONT | {2'b0, head.cp[5:0] & UTF8_MASK};
			{2'd2, 2'd0}: byte_val = UTF8_LEAD3 | {4'b0, head.cp[15:12]};
			{2'd2, 2'd1}: byte_val = UTF8_CONT | {2'b0, head.cp[11:6] & UTF8_MASK};
			{2'd2, 2'd2}: byte_val = UTF8_CONT | {2'b0, head.cp[5:0] & UTF8_MASK};
			{2'd3, 2'd0}: byte_val = UTF8_LEAD4 | {5'b0, head.cp[20:18]};
			{2'd3, 2'd1}: byte_val = UTF8_CONT | {2'b0, head.cp[17:12] & UTF8_MASK};
			{2'd3, 2'd2}: byte_val = UTF8_CONT | {2'b0, head.cp[11:6] & UTF8_MASK};
			{2'd3, 2'd3}: byte_val = UTF8_CONT | {2'b0, head.cp[5:0] & UTF8_MASK};
			default: byte_val = 8'h00;
		endcase
	end

	// A new beat goes out whenever an action is queued and the output register is empty or being drained.
	assign load    = head_valid && (!m_tvalid_q || m_tready);
	assign is_last = (idx_q == n_m1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			m_tvalid_q <= load || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= byte_val;
			m_tuser_q <= head.status;
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTH
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_BYTE) |-> (m_tlast && m_tdata == 8'h00))
		else $error("status beat not a single zero beat");
	a_multi_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == ST_BYTE && m_tdata[7]))
		else $error("non-final beat is not a UTF-8 sequence byte");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= n_m1))
		else $error("expansion index past sequence length");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for xml_text_entity_decoder_top: directed and random text with
// named and numeric references, predicted beat by beat and checked on the output stream.
// Depends on xtd_pkg and the decoder RTL.
module testbench;
	import xtd_pkg::*;

	localparam int MAX_SCAN = DEF_MAX_SCAN;
	localparam int RANDOM_ITEMS = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";
	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_LF = "f";
	localparam logic [7:0] CH_UA = "A";
	localparam logic [7:0] CH_UF = "F";

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [0:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	// Decoder state as predicted from the accepted input beats.
	logic        in_ref;
	logic [6:0]  body_len;
	logic [4:0]  cand;
	logic [1:0]  kind;
	logic [31:0] code;
	logic [3:0]  ndig;
	logic        bad;

	beat_t want_q[$];
	int    fails = 0;
	int    n_items = 0;
	int    n_results = 0;
	int    st_seen[5] = '{0, 0, 0, 0, 0};
	int    cycle_count = 0;

	// Sender burst control and receiver stall control.
	logic gaps_on = 1'b1;
	int   burst_left = 0;
	int   hold_req = 0;
	int   hold_left = 0;
	int   rx_mode = 0;
	int   rx_left = 0;
	int   rx_phase = 0;

	xml_text_entity_decoder_top #(
		.MAX_REFERENCE_SCAN(MAX_SCAN)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Entity names, right-aligned with the first character in the highest used byte.
	function automatic logic [31:0] ent_name(input int k);
		case (k)
			0: ent_name = "amp";
			1: ent_name = "lt";
			2: ent_name = "gt";
			3: ent_name = "quot";
			default: ent_name = "apos";
		endcase
	endfunction

	function automatic int name_len(input logic [31:0] nm);
		name_len = (nm[31:24] != 8'h00) ? 4 : (nm[23:16] != 8'h00) ? 3 : 2;
	endfunction

	function automatic logic [7:0] ent_glyph(input int k);
		case (k)
			0: ent_glyph = "&";
			1: ent_glyph = "<";
			2: ent_glyph = ">";
			3: ent_glyph = "\"";
			default: ent_glyph = "'";
		endcase
	endfunction

	function automatic int hex_val(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) hex_val = c - CH_ZERO;
		else if (c >= CH_LA && c <= CH_LF) hex_val = c - CH_LA + 10;
		else if (c >= CH_UA && c <= CH_UF) hex_val = c - CH_UA + 10;
		else hex_val = -1;
	endfunction

	task automatic push_want(input logic [7:0] d, input logic [2:0] st, input logic l);
		beat_t w;
		w.data = d;
		w.status = st;
		w.last = l;
		want_q = {want_q, w};
	endtask

	task automatic clear_ref();
		in_ref = 1'b0;
		body_len = '0;
		cand = 5'h1F;
		kind = KIND_NONE;
		code = '0;
		ndig = '0;
		bad = 1'b0;
	endtask

	task automatic push_status(input logic [2:0] st);
		clear_ref();
		push_want(8'h00, st, 1'b1);
	endtask

	task automatic take_digit(input logic [7:0] c);
		int d;
		if (!bad) begin
			if (kind == KIND_HEX) begin
				d = hex_val(c);
				if (d < 0 || ndig >= 4'd8) begin
					bad = 1'b1;
				end else begin
					code = {code[27:0], 4'(d)};
					ndig++;
				end
			end else if (c < CH_ZERO || c > CH_NINE || ndig >= 4'd10) begin
				bad = 1'b1;
			end else begin
				code = code * 10 + (c - CH_ZERO);
				if (code > 32'(CP_MAX)) bad = 1'b1;
				else ndig++;
			end
		end
	endtask

	task automatic take_body(input logic [7:0] c);
		logic [31:0] nm;
		int          n;
		int          idx;
		idx = body_len;
		for (int k = 0; k < 5; k++) begin
			if (cand[k]) begin
				nm = ent_name(k);
				n = name_len(nm);
				if (idx >= n) cand[k] = 1'b0;
				else if (nm[8*(n-1-idx) +: 8] != c) cand[k] = 1'b0;
			end
		end
		if (body_len == 0) begin
			if (c == CH_HASH) kind = KIND_DEC;
		end else if (kind != KIND_NONE) begin
			if (body_len == 1 && (c == CH_XL || c == CH_XU)) kind = KIND_HEX;
			else take_digit(c);
		end
		body_len++;
	endtask

	task automatic close_ref();
		logic [31:0] cp;
		logic        found;
		logic [7:0]  g;
		cp = code;
		found = 1'b0;
		g = 8'h00;
		for (int k = 0; k < 5; k++) begin
			if (!found && cand[k] && body_len == name_len(ent_name(k))) begin
				found = 1'b1;
				g = ent_glyph(k);
			end
		end
		if (found) begin
			clear_ref();
			push_want(g, ST_BYTE, 1'b1);
		end else if (kind == KIND_NONE) begin
			push_status(ST_UNKNOWN);
		end else if (bad || ndig == 0 || cp == 0 || cp > 32'(CP_MAX) ||
				(cp >= 32'(SURR_LO) && cp <= 32'(SURR_HI))) begin
			push_status(ST_MALFORMED);
		end else begin
			clear_ref();
			if (cp <= 32'(CP_1B_MAX)) begin
				push_want(cp[7:0], ST_BYTE, 1'b1);
			end else if (cp <= 32'(CP_2B_MAX)) begin
				push_want(UTF8_LEAD2 | {3'b0, cp[10:6]}, ST_BYTE, 1'b0);
				push_want(UTF8_CONT | {2'b0, cp[5:0]}, ST_BYTE, 1'b1);
			end else if (cp <= 32'(CP_3B_MAX)) begin
				push_want(UTF8_LEAD3 | {4'b0, cp[15:12]}, ST_BYTE, 1'b0);
				push_want(UTF8_CONT | {2'b0, cp[11:6]}, ST_BYTE, 1'b0);
				push_want(UTF8_CONT | {2'b0, cp[5:0]}, ST_BYTE, 1'b1);
			end else begin
				push_want(UTF8_LEAD4 | {5'b0, cp[20:18]}, ST_BYTE, 1'b0);
				push_want(UTF8_CONT | {2'b0, cp[17:12]}, ST_BYTE, 1'b0);
				push_want(UTF8_CONT | {2'b0, cp[11:6]}, ST_BYTE, 1'b0);
				push_want(UTF8_CONT | {2'b0, cp[5:0]}, ST_BYTE, 1'b1);
			end
		end
	endtask

	task automatic decode_predict(input logic [7:0] c, input logic fin);
		if (!in_ref) begin
			if (fin) push_status(ST_EARLY_END);
			else if (c == CH_LT) push_status(ST_TEXT_END);
			else if (c == CH_AMP) begin
				clear_ref();
				in_ref = 1'b1;
			end else push_want(c, ST_BYTE, 1'b1);
		end else if (fin) begin
			push_status(ST_MALFORMED);
		end else if (c == CH_SEMI) begin
			close_ref();
		end else if (body_len >= MAX_SCAN) begin
			push_status(ST_MALFORMED);
		end else begin
			take_body(c);
		end
	endtask

	// Offers one beat, holding it until the decoder takes it.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (gaps_on && burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= fin;
		do @(posedge clk); while (!s_tready);
		decode_predict(b, fin);
		n_items++;
		burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_number(input logic [31:0] cp, input logic hex, input int zeros,
			input logic upper);
		logic [7:0] dg[$];
		logic [31:0] rest;
		logic [31:0] q;
		logic [3:0]  nib;
		logic        started;
		rest = cp;
		started = 1'b0;
		if (hex) begin
			for (int i = 7; i >= 0; i--) begin
				nib = cp[4*i +: 4];
				if (started || nib != 0 || i == 0) begin
					started = 1'b1;
					if (nib < 10) dg = {dg, CH_ZERO + nib};
					else dg = {dg, (upper ? CH_UA : CH_LA) + nib - 8'd10};
				end
			end
		end else begin
			do begin
				q = rest % 10;
				dg.push_front(CH_ZERO + q[7:0]);
				rest = rest / 10;
			end while (rest != 0);
		end
		send_byte(CH_AMP, 1'b0);
		send_byte(CH_HASH, 1'b0);
		if (hex) send_byte(upper ? CH_XU : CH_XL, 1'b0);
		repeat (zeros) send_byte(CH_ZERO, 1'b0);
		foreach (dg[i]) send_byte(dg[i], 1'b0);
		send_byte(CH_SEMI, 1'b0);
	endtask

	task automatic send_long_body(input int n, input logic close);
		logic [7:0] b;
		send_byte(CH_AMP, 1'b0);
		repeat (n) begin
			b = 8'($urandom_range(97, 122));
			send_byte(b, 1'b0);
		end
		if (close) send_byte(CH_SEMI, 1'b0);
	endtask

	// Lowers valid and waits for every outstanding result beat.
	task automatic pause_sender();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (want_q.size() != 0);
		burst_left = 0;
	endtask

	task automatic check_beat();
		beat_t w;
		n_results++;
		if (m_tuser < 5) st_seen[m_tuser]++;
		if (want_q.size() == 0) begin
			$error("unexpected result beat: out_byte %02h status %0d last %0d",
				m_tdata, m_tuser, m_tlast);
			fails++;
		end else begin
			w = want_q.pop_front();
			if (m_tdata !== w.data) begin
				$error("out_byte: expected %02h, got %02h", w.data, m_tdata);
				fails++;
			end
			if (m_tuser !== w.status) begin
				$error("status: expected %0d, got %0d", w.status, m_tuser);
				fails++;
			end
			if (m_tlast !== w.last) begin
				$error("last: expected %0d, got %0d", w.last, m_tlast);
				fails++;
			end
		end
	endtask

	// Output side: check each accepted beat, then pick the next ready value.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_beat();
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		rx_phase++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left <= 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_phase % 3) != 2;
			endcase
		end
	end

	task automatic test_plain_text();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(CH_LT, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_named_entities();
		send_text("&amp;&lt;&gt;&quot;&apos;");
		send_text("&;&ampx;&am;&Amp;");
	endtask

	task automatic test_numeric_refs();
		send_text("&#65;&#x7FF;&#X20AC;&#x1f600;&#1114111;&#x10FFFF;");
		send_text("&#0;&#xD800;&#xdfff;&#1114112;&#x110000;&#;&#x;&#1a;");
		// Ten decimal digits still fit, eleven do not; nine hex digits are too many.
		send_text("&#0000000065;&#00000000065;&#x000000041;");
	endtask

	task automatic test_reference_breaks();
		send_text("&a<b;&#12<;");
		send_text("&#12");
		send_byte(8'h3B, 1'b1);
		// A full body followed by anything but a semicolon is cut off there.
		send_long_body(MAX_SCAN, 1'b0);
		send_byte("q", 1'b0);
		send_long_body(MAX_SCAN, 1'b1);
		send_text("&#x");
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_backpressure();
		pause_sender();
		gaps_on = 1'b0;
		hold_req = 300;
		for (int i = 0; i < 4; i++) begin
			send_text("&#x1F600;");
			send_byte(8'(8'h41 + i), 1'b0);
		end
		pause_sender();
		gaps_on = 1'b1;
	endtask

	task automatic rand_segment();
		int          pick;
		int          k;
		int          n;
		logic [31:0] nm;
		logic [31:0] cp;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
		if (pick < 30) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b, 1'b0);
		end else if (pick < 45) begin
			k = $urandom_range(0, 4);
			nm = ent_name(k);
			n = name_len(nm);
			send_byte(CH_AMP, 1'b0);
			for (int p = 0; p < n; p++) begin
				b = nm[8*(n-1-p) +: 8];
				if ($urandom_range(0, 11) == 0) b = 8'($urandom_range(97, 122));
				send_byte(b, 1'b0);
			end
			send_byte(CH_SEMI, 1'b0);
		end else if (pick < 75) begin
			case ($urandom_range(0, 5))
				0: cp = $urandom_range(1, 32'h7F);
				1: cp = $urandom_range(32'h80, 32'h7FF);
				2: cp = $urandom_range(32'h800, 32'hFFFF);
				3: cp = $urandom_range(32'h10000, 32'h10FFFF);
				4: begin
					case ($urandom_range(0, 6))
						0: cp = 32'h0;
						1: cp = 32'h10FFFF;
						2: cp = 32'h110000;
						3: cp = 32'hD7FF;
						4: cp = 32'hD800;
						5: cp = 32'hDFFF;
						default: cp = 32'hE000;
					endcase
				end
				default: cp = $urandom();
			endcase
			send_number(cp, 1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
				1'($urandom_range(0, 1)));
		end else if (pick < 85) begin
			// Numeric reference with junk among the digits.
			send_byte(CH_AMP, 1'b0);
			send_byte(CH_HASH, 1'b0);
			if ($urandom_range(0, 1)) send_byte(CH_XL, 1'b0);
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 2))
					0: b = 8'(CH_ZERO + $urandom_range(0, 9));
					1: b = 8'($urandom_range(97, 122));
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, 1'b0);
			end
			send_byte(CH_SEMI, 1'b0);
		end else if (pick < 92) begin
			send_byte(CH_AMP, 1'b0);
			repeat ($urandom_range(1, 6)) begin
				b = 8'($urandom_range(97, 122));
				send_byte(b, 1'b0);
			end
			send_byte(CH_SEMI, 1'b0);
		end else if (pick < 96) begin
			send_byte(CH_AMP, 1'b0);
			if ($urandom_range(0, 1)) send_byte(CH_HASH, 1'b0);
			repeat ($urandom_range(0, 3)) begin
				b = 8'(CH_ZERO + $urandom_range(0, 9));
				send_byte(b, 1'b0);
			end
			if ($urandom_range(0, 1)) begin
				b = 8'($urandom_range(0, 255));
				send_byte(b, 1'b1);
			end else begin
				send_byte(CH_LT, 1'b0);
				send_byte(CH_SEMI, 1'b0);
			end
		end else if (pick < 98) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b, 1'b1);
		end else begin
			send_long_body($urandom_range(MAX_SCAN - 4, MAX_SCAN + 4), 1'b1);
		end
	endtask

	task automatic test_random_text();
		int stop_at;
		stop_at = n_items + RANDOM_ITEMS;
		while (n_items < stop_at) rand_segment();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		clear_ref();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_text();
		test_named_entities();
		test_numeric_refs();
		test_reference_breaks();
		test_backpressure();
		test_random_text();
		s_tvalid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d input beats and checked %0d result beats.", n_items, n_results);
		$display("Statuses seen: %0d bytes, %0d text ends, %0d malformed, %0d unknown,",
			st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
		$display("and %0d early ends.", st_seen[4]);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
